// ----- hdl/pwft_pkg.sv -----
// shared types and constants of the pulse width frame transmitter
`timescale 1ns / 1ps

package pwft_pkg;

   // field and register widths
   localparam int unsigned CFG_W       = 12;
   localparam int unsigned REP_W       = 3;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned NUM_DUR     = 6;
   localparam int unsigned DUR_IDX_W   = 3;
   localparam int unsigned FRAME_W     = 40;
   localparam int unsigned POS_W       = 6;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // element positions: start pulse first, trailing zero bit last
   localparam logic [POS_W-1:0] POS_START = 6'd0;
   localparam logic [POS_W-1:0] POS_LAST  = 6'd41;

   localparam logic [7:0] POWER_MAX = 8'd99;

   // register defaults after reset
   localparam logic [CFG_W-1:0] START_HIGH_RST = 12'd1550;
   localparam logic [CFG_W-1:0] START_LOW_RST  = 12'd660;
   localparam logic [CFG_W-1:0] ONE_HIGH_RST   = 12'd830;
   localparam logic [CFG_W-1:0] ONE_LOW_RST    = 12'd200;
   localparam logic [CFG_W-1:0] ZERO_HIGH_RST  = 12'd360;
   localparam logic [CFG_W-1:0] ZERO_LOW_RST   = 12'd670;
   localparam logic [REP_W-1:0] REPEAT_RST     = 3'd3;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_HIGH = 3'd0,
      CSR_START_LOW  = 3'd1,
      CSR_ONE_HIGH   = 3'd2,
      CSR_ONE_LOW    = 3'd3,
      CSR_ZERO_HIGH  = 3'd4,
      CSR_ZERO_LOW   = 3'd5,
      CSR_REPEAT     = 3'd6
   } csr_idx_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] device_id;
      logic [3:0]  channel;
      logic [3:0]  mode;
      logic [7:0]  power;
   } req_word_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic load_rejected;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     value;
   } csr_word_type;

   // live register set handed to the sequencer
   typedef struct packed {
      logic [NUM_DUR-1:0][CFG_W-1:0] duration;
      logic [REP_W-1:0]              repeat_count;
   } cfg_type;

   // classified word waiting in the queue
   typedef struct packed {
      cmd_type              command;
      logic [FRAME_W-1:0]   frame;
   } q_entry_type;

endpackage

// ----- hdl/pwft_chan_if.sv -----
// valid/ready channel carrying one word of a chosen payload type
`timescale 1ns / 1ps

interface pwft_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/pwft_front.sv -----
// front end: takes request words, classifies them and builds the frame bits
`timescale 1ns / 1ps

module pwft_front (
   pwft_chan_if.sink             req_chan,
   input  logic                  q_full,
   output logic                  push,
   output pwft_pkg::q_entry_type entry
);

   logic [7:0] byte0;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic [7:0] byte3;
   logic [7:0] csum;

   // accept whenever the queue has room
   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   // frame bytes, power saturated, 8-bit checksum
   always_comb begin
      byte0 = req_chan.data.device_id[7:0];
      byte1 = req_chan.data.device_id[15:8];
      byte2 = {req_chan.data.channel, req_chan.data.mode};
      byte3 = (req_chan.data.power > pwft_pkg::POWER_MAX) ? pwft_pkg::POWER_MAX
                                                          : req_chan.data.power;
      csum  = byte0 + byte1 + byte2 + byte3;
   end

   assign entry.command = req_chan.data.command;
   assign entry.frame   = {byte0, byte1, byte2, byte3, csum};

endmodule

// ----- hdl/pwft_queue.sv -----
// short queue between the front end and the sequencer
`timescale 1ns / 1ps

module pwft_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pwft_pkg::q_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output pwft_pkg::q_entry_type head,
   output logic                  head_valid
);

   pwft_pkg::q_entry_type               store_ff [pwft_pkg::QUEUE_DEPTH];
   logic [pwft_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [pwft_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [pwft_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign full       = (count_ff == pwft_pkg::QCNT_W'(pwft_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pwft_pkg::QPTR_W'(pwft_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pwft_pkg::QPTR_W'(pwft_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/pwft_back.sv -----
// back end: pulse sequencer and registered response word
`timescale 1ns / 1ps

module pwft_back #(
   parameter int unsigned TIMER_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pwft_pkg::cfg_type     cfg,
   input  pwft_pkg::q_entry_type head,
   input  logic                  head_valid,
   output logic                  pop,
   pwft_chan_if.source           rsp_chan
);

   localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;
   localparam int unsigned WIDE_W    = 17;

   logic [pwft_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [pwft_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                         phase_high_ff, phase_high_in;
   logic [TIMER_BITS-1:0]        dur_ff, dur_in;
   logic [pwft_pkg::REP_W-1:0]   repeats_ff, repeats_in;
   logic                         active_ff, active_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pwft_pkg::rsp_word_type       rsp_data_ff, rsp_data_in;

   logic [pwft_pkg::POS_W-1:0]   pos_next;
   logic [pwft_pkg::REP_W-1:0]   repeats_dec;

   // zero means one tick, above the timer range saturates
   function automatic logic [TIMER_BITS-1:0] fit_duration(
      input logic [pwft_pkg::CFG_W-1:0] v
   );
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(v);
      if (v == '0) begin
         return TIMER_BITS'(1);
      end else if (wide > WIDE_W'(TIMER_MAX)) begin
         return TIMER_BITS'(TIMER_MAX);
      end
      return TIMER_BITS'(v);
   endfunction

   // duration of one phase of the element at pos
   function automatic logic [TIMER_BITS-1:0] phase_duration(
      input pwft_pkg::cfg_type            c,
      input logic [pwft_pkg::FRAME_W-1:0] frame,
      input logic [pwft_pkg::POS_W-1:0]   pos,
      input logic                         high
   );
      logic [pwft_pkg::DUR_IDX_W-1:0] base;
      logic [pwft_pkg::POS_W-1:0]     bit_idx;
      bit_idx = pwft_pkg::POS_W'(pwft_pkg::FRAME_W) - pos;
      if (pos == pwft_pkg::POS_START) begin
         base = pwft_pkg::DUR_IDX_W'(pwft_pkg::CSR_START_HIGH);
      end else if (pos < pwft_pkg::POS_LAST && frame[bit_idx]) begin
         base = pwft_pkg::DUR_IDX_W'(pwft_pkg::CSR_ONE_HIGH);
      end else begin
         base = pwft_pkg::DUR_IDX_W'(pwft_pkg::CSR_ZERO_HIGH);
      end
      if (!high) begin
         base = base + 1'b1;
      end
      return fit_duration(c.duration[base]);
   endfunction

   assign pos_next    = pos_ff + 1'b1;
   assign repeats_dec = repeats_ff - 1'b1;

   // take the head word when the output register is free or draining
   assign pop = head_valid && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer step and response word
   always_comb begin
      frame_in      = frame_ff;
      pos_in        = pos_ff;
      phase_high_in = phase_high_ff;
      dur_in        = dur_ff;
      repeats_in    = repeats_ff;
      active_in     = active_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (pop) begin
         rsp_valid_in = 1'b1;
         case (head.command)
            pwft_pkg::CMD_LOAD: begin
               if (active_ff) begin
                  rsp_data_in = '{pin_level: phase_high_ff, busy_res: 1'b1,
                                  load_rejected: 1'b1};
               end else begin
                  frame_in      = head.frame;
                  repeats_in    = (cfg.repeat_count == '0) ? pwft_pkg::REP_W'(1)
                                                           : cfg.repeat_count;
                  active_in     = 1'b1;
                  pos_in        = pwft_pkg::POS_START;
                  phase_high_in = 1'b1;
                  dur_in        = fit_duration(cfg.duration[
                                     pwft_pkg::DUR_IDX_W'(pwft_pkg::CSR_START_HIGH)]);
                  rsp_data_in   = '{pin_level: 1'b1, busy_res: 1'b1,
                                    load_rejected: 1'b0};
               end
            end
            default: begin
               rsp_data_in = '{pin_level: phase_high_ff, busy_res: active_ff,
                               load_rejected: 1'b0};
               if (active_ff) begin
                  if (dur_ff > TIMER_BITS'(1)) begin
                     dur_in = dur_ff - 1'b1;
                  end else if (phase_high_ff) begin
                     phase_high_in = 1'b0;
                     dur_in        = phase_duration(cfg, frame_ff, pos_ff, 1'b0);
                  end else if (pos_ff < pwft_pkg::POS_LAST) begin
                     pos_in        = pos_next;
                     phase_high_in = 1'b1;
                     dur_in        = phase_duration(cfg, frame_ff, pos_next, 1'b1);
                  end else begin
                     repeats_in = repeats_dec;
                     if (repeats_dec == '0) begin
                        active_in     = 1'b0;
                        phase_high_in = 1'b0;
                        pos_in        = pwft_pkg::POS_START;
                        dur_in        = '0;
                     end else begin
                        pos_in        = pwft_pkg::POS_START;
                        phase_high_in = 1'b1;
                        dur_in        = phase_duration(cfg, frame_ff,
                                                       pwft_pkg::POS_START, 1'b1);
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff      <= '0;
         pos_ff        <= '0;
         phase_high_ff <= 1'b0;
         dur_ff        <= '0;
         repeats_ff    <= '0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         frame_ff      <= frame_in;
         pos_ff        <= pos_in;
         phase_high_ff <= phase_high_in;
         dur_ff        <= dur_in;
         repeats_ff    <= repeats_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // idle sequencer sits at the start position with the pin low
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (!phase_high_ff && pos_ff == pwft_pkg::POS_START && dur_ff == '0))
      else $error("idle sequencer holds stale phase state");

   // position never runs past the trailing zero bit
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= pwft_pkg::POS_LAST)
      else $error("element position out of range");

   // a running phase always has ticks left and frames to send
   a_active_counts: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (dur_ff != '0 && repeats_ff != '0))
      else $error("active sequencer with empty timer or repeat count");

   // a word is only taken when the output register can hold the result
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> ($stable(rsp_data_ff) && rsp_valid_ff))
      else $error("stalled response word overwritten");

endmodule

// ----- hdl/pulse_width_frame_transmitter.sv -----
// top level of the pulse width frame transmitter: register file and part wiring
//
//   port      dir   word           notes
//   req_chan  in    req_word_type  load (command 0) or one microsecond tick (command 1)
//   rsp_chan  out   rsp_word_type  one word per request: pin level, busy, load rejected
//   csr_chan  in    csr_word_type  register write, index 0..6, always ready
//
// one request word per cycle sustained while responses are taken; a taken request
// is registered in the two-entry queue by the front end and its response in the
// output register by the sequencer. reset clears the queue, the sequencer and the
// response register and restores register defaults. a stalled response holds the
// sequencer while the queue still takes up to two more words.
`timescale 1ns / 1ps

module pulse_width_frame_transmitter #(
   parameter int unsigned TIMER_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   pwft_chan_if.sink   req_chan,
   pwft_chan_if.source rsp_chan,
   pwft_chan_if.sink   csr_chan
);

   pwft_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  q_full;
   logic                  q_push;
   pwft_pkg::q_entry_type q_push_entry;
   logic                  q_pop;
   pwft_pkg::q_entry_type q_head;
   logic                  q_head_valid;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (pwft_pkg::csr_idx_type'(csr_chan.data.index))
            pwft_pkg::CSR_START_HIGH, pwft_pkg::CSR_START_LOW,
            pwft_pkg::CSR_ONE_HIGH,   pwft_pkg::CSR_ONE_LOW,
            pwft_pkg::CSR_ZERO_HIGH,  pwft_pkg::CSR_ZERO_LOW: begin
               cfg_in.duration[csr_chan.data.index] = csr_chan.data.value;
            end
            pwft_pkg::CSR_REPEAT: begin
               cfg_in.repeat_count = csr_chan.data.value[pwft_pkg::REP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duration[pwft_pkg::CSR_START_HIGH] <= pwft_pkg::START_HIGH_RST;
         cfg_ff.duration[pwft_pkg::CSR_START_LOW]  <= pwft_pkg::START_LOW_RST;
         cfg_ff.duration[pwft_pkg::CSR_ONE_HIGH]   <= pwft_pkg::ONE_HIGH_RST;
         cfg_ff.duration[pwft_pkg::CSR_ONE_LOW]    <= pwft_pkg::ONE_LOW_RST;
         cfg_ff.duration[pwft_pkg::CSR_ZERO_HIGH]  <= pwft_pkg::ZERO_HIGH_RST;
         cfg_ff.duration[pwft_pkg::CSR_ZERO_LOW]   <= pwft_pkg::ZERO_LOW_RST;
         cfg_ff.repeat_count                       <= pwft_pkg::REPEAT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   pwft_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (q_push),
      .entry    (q_push_entry)
   );

   // queue
   pwft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid)
   );

   // sequencer
   pwft_back #(
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (q_head),
      .head_valid (q_head_valid),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- sim/tb_pulse_width_frame_transmitter.sv -----
// self-checking testbench of the pulse width frame transmitter: frame timing, loads and registers
`timescale 1ns / 1ps

module tb_pulse_width_frame_transmitter;

   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned RANDOM_WORDS   = 500;
   localparam int unsigned PHASE_WORDS    = 120;
   localparam int unsigned REPORT_LIMIT   = 10;
   // index past the register map, must be ignored
   localparam logic [pwft_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   logic clock;
   logic reset;

   pwft_chan_if #(.payload_type(pwft_pkg::req_word_type)) req_if ();
   pwft_chan_if #(.payload_type(pwft_pkg::rsp_word_type)) rsp_if ();
   pwft_chan_if #(.payload_type(pwft_pkg::csr_word_type)) csr_if ();

   pulse_width_frame_transmitter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // pin timing predictor with its own copy of registers and sequencer state
   class pin_tracker;
      logic [pwft_pkg::CFG_W-1:0]   dur [pwft_pkg::NUM_DUR];
      logic [pwft_pkg::REP_W-1:0]   rep_cfg;
      logic [pwft_pkg::FRAME_W-1:0] frame_bits;
      logic [pwft_pkg::POS_W-1:0]   pos;
      bit                           phase_high;
      logic [pwft_pkg::CFG_W-1:0]   ticks_left;
      logic [pwft_pkg::REP_W-1:0]   reps_left;
      bit                           active;
      pwft_pkg::rsp_word_type       pending [$];
      int loads, rejects, ticks, frames_sent, csr_writes, checked, failures;

      function new();
         dur[pwft_pkg::CSR_START_HIGH] = pwft_pkg::START_HIGH_RST;
         dur[pwft_pkg::CSR_START_LOW]  = pwft_pkg::START_LOW_RST;
         dur[pwft_pkg::CSR_ONE_HIGH]   = pwft_pkg::ONE_HIGH_RST;
         dur[pwft_pkg::CSR_ONE_LOW]    = pwft_pkg::ONE_LOW_RST;
         dur[pwft_pkg::CSR_ZERO_HIGH]  = pwft_pkg::ZERO_HIGH_RST;
         dur[pwft_pkg::CSR_ZERO_LOW]   = pwft_pkg::ZERO_LOW_RST;
         rep_cfg    = pwft_pkg::REPEAT_RST;
         frame_bits = '0;
         pos        = pwft_pkg::POS_START;
         phase_high = 0;
         ticks_left = '0;
         reps_left  = '0;
         active     = 0;
      endfunction

      function void write_reg(pwft_pkg::csr_word_type w);
         csr_writes++;
         case (w.index)
            pwft_pkg::CSR_START_HIGH, pwft_pkg::CSR_START_LOW, pwft_pkg::CSR_ONE_HIGH,
            pwft_pkg::CSR_ONE_LOW, pwft_pkg::CSR_ZERO_HIGH,
            pwft_pkg::CSR_ZERO_LOW: dur[w.index] = w.value;
            pwft_pkg::CSR_REPEAT: rep_cfg = w.value[pwft_pkg::REP_W-1:0];
            default: ;
         endcase
      endfunction

      // length of one phase of an element, a zero register counts as one tick
      function logic [pwft_pkg::CFG_W-1:0] phase_len(logic [pwft_pkg::POS_W-1:0] p, bit high);
         logic [pwft_pkg::CFG_W-1:0] v;
         if (p == pwft_pkg::POS_START) begin
            v = high ? dur[pwft_pkg::CSR_START_HIGH] : dur[pwft_pkg::CSR_START_LOW];
         end else if (p <= pwft_pkg::FRAME_W && frame_bits[pwft_pkg::FRAME_W - p]) begin
            v = high ? dur[pwft_pkg::CSR_ONE_HIGH] : dur[pwft_pkg::CSR_ONE_LOW];
         end else begin
            v = high ? dur[pwft_pkg::CSR_ZERO_HIGH] : dur[pwft_pkg::CSR_ZERO_LOW];
         end
         return (v == '0) ? pwft_pkg::CFG_W'(1) : v;
      endfunction

      function void start_frame();
         pos        = pwft_pkg::POS_START;
         phase_high = 1;
         ticks_left = phase_len(pwft_pkg::POS_START, 1);
      endfunction

      function void take_word(pwft_pkg::req_word_type w);
         pwft_pkg::rsp_word_type want;
         logic [7:0] b0, b1, b2, b3, b4;
         want = '0;
         if (w.command == pwft_pkg::CMD_LOAD) begin
            if (active) begin
               // turned away, state untouched
               rejects++;
               want.pin_level     = phase_high;
               want.busy_res      = 1'b1;
               want.load_rejected = 1'b1;
            end else begin
               loads++;
               b0 = w.device_id[7:0];
               b1 = w.device_id[15:8];
               b2 = {w.channel, w.mode};
               b3 = (w.power > pwft_pkg::POWER_MAX) ? pwft_pkg::POWER_MAX : w.power;
               b4 = b0 + b1 + b2 + b3;
               frame_bits = {b0, b1, b2, b3, b4};
               reps_left  = (rep_cfg == '0) ? pwft_pkg::REP_W'(1) : rep_cfg;
               active     = 1;
               start_frame();
               want.pin_level = 1'b1;
               want.busy_res  = 1'b1;
            end
         end else begin
            ticks++;
            if (active) begin
               want.pin_level = phase_high;
               want.busy_res  = 1'b1;
               // advance one microsecond
               if (ticks_left > 1) begin
                  ticks_left--;
               end else if (phase_high) begin
                  phase_high = 0;
                  ticks_left = phase_len(pos, 0);
               end else if (pos < pwft_pkg::POS_LAST) begin
                  pos++;
                  phase_high = 1;
                  ticks_left = phase_len(pos, 1);
               end else begin
                  frames_sent++;
                  reps_left--;
                  if (reps_left == '0) begin
                     active     = 0;
                     phase_high = 0;
                     pos        = pwft_pkg::POS_START;
                     ticks_left = '0;
                  end else begin
                     start_frame();
                  end
               end
            end
         end
         pending.push_back(want);
      endfunction

      function void report(string what, pwft_pkg::rsp_word_type want,
                           pwft_pkg::rsp_word_type got);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("%0t: %s: expected pin %b busy %b rejected %b, got pin %b busy %b rejected %b",
                     $time, what, want.pin_level, want.busy_res, want.load_rejected,
                     got.pin_level, got.busy_res, got.load_rejected);
      endfunction

      function void check_word(pwft_pkg::rsp_word_type got);
         pwft_pkg::rsp_word_type want;
         checked++;
         if (pending.size() == 0) begin
            report("response word with nothing outstanding", '0, got);
            return;
         end
         want = pending.pop_front();
         if (got.pin_level !== want.pin_level || got.busy_res !== want.busy_res ||
             got.load_rejected !== want.load_rejected)
            report("response word differs", want, got);
      endfunction
   endclass

   pin_tracker  tracker;
   int          idle_cycles = 0;
   int          gap_max = 0;
   int          burst_left = 0;
   logic [15:0] rsp_pattern = '1;
   logic [3:0]  rsp_step = '0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side: check accepted words, stall on a rotating pattern, hold off in reset
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.check_word(rsp_if.data);
      rsp_step     <= rsp_step + 4'd1;
      rsp_if.ready <= !reset && rsp_pattern[rsp_step];
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // 0 no idling, 1 light, 2 heavy
   function automatic void set_idling(int level);
      case (level)
         0: begin
            gap_max     = 0;
            rsp_pattern = '1;
         end
         1: begin
            gap_max     = 3;
            rsp_pattern = 16'($urandom_range(16'hFFFF)) | 16'h5555;
         end
         default: begin
            gap_max     = 12;
            rsp_pattern = 16'($urandom_range(16'hFFFF)) | 16'h0101;
         end
      endcase
   endfunction

   function automatic pwft_pkg::req_word_type random_load();
      pwft_pkg::req_word_type w;
      w.command = pwft_pkg::CMD_LOAD;
      case ($urandom_range(7))
         0: w.device_id = '0;
         1: w.device_id = '1;
         default: w.device_id = 16'($urandom_range(16'hFFFF));
      endcase
      w.channel = 4'($urandom_range(15));
      w.mode    = 4'($urandom_range(15));
      w.power   = ($urandom_range(3) == 0) ? 8'($urandom_range(90, 110))
                                           : 8'($urandom_range(255));
      return w;
   endfunction

   function automatic pwft_pkg::req_word_type tick_word();
      pwft_pkg::req_word_type w;
      w = random_load();
      w.command = pwft_pkg::CMD_TICK;
      return w;
   endfunction

   // mostly one tick, now and then a little longer
   function automatic logic [pwft_pkg::CFG_W-1:0] random_dur();
      int r;
      r = $urandom_range(19);
      if (r < 14) return pwft_pkg::CFG_W'($urandom_range(1));
      if (r < 19) return pwft_pkg::CFG_W'($urandom_range(2, 3));
      return pwft_pkg::CFG_W'($urandom_range(4, 12));
   endfunction

   // repeat count with random upper bits that the register drops
   function automatic logic [pwft_pkg::CFG_W-1:0] random_repeat();
      int r;
      logic [pwft_pkg::REP_W-1:0] n;
      r = $urandom_range(19);
      n = (r < 10) ? pwft_pkg::REP_W'($urandom_range(1)) :
          (r < 17) ? pwft_pkg::REP_W'($urandom_range(2, 3)) :
                     pwft_pkg::REP_W'($urandom_range(4, 7));
      return {9'($urandom_range(511)), n};
   endfunction

   // send one request word, idling between bursts
   task automatic send_word(input pwft_pkg::req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.take_word(w);
   endtask

   task automatic idle_ticks(input int n);
      repeat (n) send_word(tick_word());
   endtask

   task automatic drain();
      while (tracker.active) send_word(tick_word());
   endtask

   // one load, then ticks until the last frame is out, with stray loads mixed in
   task automatic run_frames(input pwft_pkg::req_word_type ld, input int reject_pct);
      send_word(ld);
      while (tracker.active) begin
         if ($urandom_range(99) < reject_pct) send_word(random_load());
         else send_word(tick_word());
      end
   endtask

   // wait for every outstanding response and let the pipeline empty
   task automatic settle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pwft_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pwft_pkg::CFG_W-1:0] val);
      pwft_pkg::csr_word_type w;
      w.index = idx;
      w.value = val;
      csr_if.valid <= 1'b1;
      csr_if.data  <= w;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      tracker.write_reg(w);
   endtask

   task automatic program_regs(input logic [pwft_pkg::CFG_W-1:0] sh, sl, oh, ol, zh, zl, rep,
                               input bit spare);
      settle();
      if (spare) write_csr(CSR_SPARE, pwft_pkg::CFG_W'($urandom_range(4095)));
      write_csr(pwft_pkg::CSR_START_HIGH, sh);
      write_csr(pwft_pkg::CSR_START_LOW, sl);
      write_csr(pwft_pkg::CSR_ONE_HIGH, oh);
      write_csr(pwft_pkg::CSR_ONE_LOW, ol);
      write_csr(pwft_pkg::CSR_ZERO_HIGH, zh);
      write_csr(pwft_pkg::CSR_ZERO_LOW, zl);
      write_csr(pwft_pkg::CSR_REPEAT, rep);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      pwft_pkg::req_word_type ld;
      int base_words;
      int phase_base;
      int pick;

      tracker = new();
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ticks while idle, then short frames where a one bit outlasts a zero bit
      set_idling(1);
      idle_ticks(3);
      settle();
      write_csr(pwft_pkg::CSR_START_HIGH, 12'd2);
      write_csr(pwft_pkg::CSR_START_LOW, 12'd1);
      write_csr(pwft_pkg::CSR_ONE_HIGH, 12'd1);
      write_csr(pwft_pkg::CSR_ONE_LOW, 12'd2);
      write_csr(pwft_pkg::CSR_ZERO_HIGH, 12'd1);
      write_csr(pwft_pkg::CSR_ZERO_LOW, 12'd0);
      write_csr(pwft_pkg::CSR_REPEAT, 12'hFF9);
      csr_if.valid <= 1'b0;

      // smallest fields, then a largest-field load turned away mid-frame
      ld = '0;
      ld.command = pwft_pkg::CMD_LOAD;
      send_word(ld);
      idle_ticks(5);
      ld.device_id = '1;
      ld.channel   = '1;
      ld.mode      = '1;
      ld.power     = '1;
      send_word(ld);
      drain();

      // power saturation edges
      ld.power = pwft_pkg::POWER_MAX;
      run_frames(ld, 0);
      ld.power = pwft_pkg::POWER_MAX + 8'd1;
      ld.device_id = 16'h8000;
      run_frames(ld, 0);
      idle_ticks(2);

      // zero lengths at the largest repeat count, plus a write past the register map
      program_regs('0, '0, '0, '0, '0, '0, 12'hFFF, 1);
      run_frames(random_load(), 10);

      // long start pulse and a zero repeat count
      set_idling(0);
      program_regs(12'd16, 12'd16, '0, '0, 12'd1, 12'd1, 12'hFF8, 0);
      run_frames(random_load(), 0);

      // long one bits on a frame with only two ones
      set_idling(1);
      program_regs(12'd1, 12'd1, 12'd12, 12'd12, '0, 12'd1, 12'd1, 0);
      ld = '0;
      ld.command   = pwft_pkg::CMD_LOAD;
      ld.device_id = 16'h0001;
      run_frames(ld, 0);

      // long zero bits on a frame that is mostly ones
      set_idling(0);
      program_regs(12'd2, 12'd1, 12'd1, 12'd2, 12'd6, 12'd6, 12'd1, 0);
      ld.device_id = '1;
      ld.channel   = '1;
      ld.mode      = '1;
      ld.power     = pwft_pkg::POWER_MAX;
      run_frames(ld, 1);

      // random phases, each with its own timing and idling
      base_words = tracker.loads + tracker.ticks;
      while (tracker.loads + tracker.ticks - base_words < RANDOM_WORDS) begin
         program_regs(random_dur(), random_dur(), random_dur(), random_dur(),
                      random_dur(), random_dur(), random_repeat(), $urandom_range(3) == 0);
         set_idling($urandom_range(2));
         phase_base = tracker.loads + tracker.ticks;
         while (tracker.loads + tracker.ticks - phase_base < PHASE_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               run_frames(random_load(), $urandom_range(3));
            end else if (pick < 88) begin
               idle_ticks($urandom_range(1, 6));
            end else begin
               // noise: loads and ticks in any order
               repeat ($urandom_range(1, 4)) begin
                  ld = random_load();
                  if ($urandom_range(1)) ld.command = pwft_pkg::CMD_TICK;
                  send_word(ld);
               end
            end
         end
         drain();
      end

      settle();
      $display("covered %0d loads (%0d turned away while busy), %0d ticks, %0d frames sent",
               tracker.loads, tracker.rejects, tracker.ticks, tracker.frames_sent);
      $display("%0d register writes incl. extreme lengths, %0d response words checked",
               tracker.csr_writes, tracker.checked);
      if (tracker.failures == 0 && tracker.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures, %0d responses outstanding",
                  tracker.failures, tracker.pending.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
